// ===== rtl/zep_pkg.sv =====
// ----------------------------------------------------------------------------
// zep_pkg
// Shared types and constants for the Z-Y-Z Euler pose matrix core.
// ----------------------------------------------------------------------------
`default_nettype none

package zep_pkg;

    // Number of register stages from input to output.
    localparam int unsigned N_STAGES = 7;
    localparam int unsigned N_SIN_STAGES = 4;
    localparam int unsigned N_MAT_STAGES = 3;
    localparam int unsigned N_ROT = 9;

    // Sine polynomial coefficients, unsigned Q28.
    localparam logic [28:0] SIN_A = 29'd421657428;
    localparam logic [27:0] SIN_B = 28'd172226216;
    localparam logic [24:0] SIN_C = 25'd19004244;

    localparam logic [15:0] PHASE_QUARTER = 16'd16384;
    localparam logic [14:0] Q14_ONE_U = 15'd16384;
    localparam logic signed [19:0] Q14_POS_ONE = 20'sd16384;
    localparam logic signed [19:0] Q14_NEG_ONE = -20'sd16384;
    localparam logic signed [47:0] ROUND_HALF = 48'sd134217728;

    // Entries whose first or second Q42 term enters the sum negated,
    // in output order r0c0 r1c0 r2c0 r0c1 r1c1 r2c1 r0c2 r1c2 r2c2.
    localparam logic [N_ROT-1:0] ROT_NEG_A = 9'b000_011_100;
    localparam logic [N_ROT-1:0] ROT_NEG_B = 9'b000_001_001;

    typedef struct packed {
        logic [N_SIN_STAGES-1:0] sin_en;
        logic [N_MAT_STAGES-1:0] mat_en;
    } t_pipe_ctl;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } t_pos;

    typedef logic signed [15:0] t_q14;

endpackage

`default_nettype wire

// ===== rtl/zep_if.sv =====
// ----------------------------------------------------------------------------
// zep_in_if / zep_out_if
// Valid/ready channels carrying pose angles in and the pose matrix out.
// ----------------------------------------------------------------------------
`default_nettype none

interface zep_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] angle_alpha;
    logic signed [15:0] angle_beta;
    logic signed [15:0] angle_gamma;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;

    modport source (output valid, angle_alpha, angle_beta, angle_gamma,
                    pos_x, pos_y, pos_z, input ready);
    modport sink   (input valid, angle_alpha, angle_beta, angle_gamma,
                    pos_x, pos_y, pos_z, output ready);
endinterface

interface zep_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] rot_r0c0;
    logic signed [15:0] rot_r1c0;
    logic signed [15:0] rot_r2c0;
    logic signed [15:0] rot_r0c1;
    logic signed [15:0] rot_r1c1;
    logic signed [15:0] rot_r2c1;
    logic signed [15:0] rot_r0c2;
    logic signed [15:0] rot_r1c2;
    logic signed [15:0] rot_r2c2;
    logic signed [31:0] trans_x;
    logic signed [31:0] trans_y;
    logic signed [31:0] trans_z;

    modport source (output valid, rot_r0c0, rot_r1c0, rot_r2c0, rot_r0c1, rot_r1c1,
                    rot_r2c1, rot_r0c2, rot_r1c2, rot_r2c2, trans_x, trans_y,
                    trans_z, input ready);
    modport sink   (input valid, rot_r0c0, rot_r1c0, rot_r2c0, rot_r0c1, rot_r1c1,
                    rot_r2c1, rot_r0c2, rot_r1c2, rot_r2c2, trans_x, trans_y,
                    trans_z, output ready);
endinterface

`default_nettype wire

// ===== rtl/zep_sine.sv =====
// ----------------------------------------------------------------------------
// zep_sine
// Four-stage pipelined sine of a 16-bit binary angle, result in Q1.14.
// ----------------------------------------------------------------------------
`default_nettype none

module zep_sine
    import zep_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic [N_SIN_STAGES-1:0] i_en,
    input  wire logic [15:0]             i_phase,
    output t_q14                         o_sin
);

    logic [14:0] n_x;
    logic [14:0] r_x_a, r_x_b, r_x_c;
    logic [28:0] r_x2_a, r_x2_b;
    logic [1:0]  r_quad_a, r_quad_b, r_quad_c;
    logic [27:0] r_u;
    logic [28:0] r_w;
    t_q14        r_sin;

    logic [53:0] cx2;
    logic [27:0] n_u;
    logic [56:0] ux2;
    logic [28:0] n_w;
    logic [43:0] wx;
    logic [14:0] mag;

    // The offset is mirrored in odd quadrants so the polynomial covers 0..pi/2.
    always_comb begin
        if (i_phase[14]) begin
            n_x = Q14_ONE_U - {1'b0, i_phase[13:0]};
        end else begin
            n_x = {1'b0, i_phase[13:0]};
        end
    end

    assign cx2 = 54'(SIN_C) * 54'(r_x2_a);
    assign n_u = SIN_B - 28'(cx2[53:28]);
    assign ux2 = 57'(r_u) * 57'(r_x2_b);
    assign n_w = SIN_A - 29'(ux2[56:28]);
    assign wx  = 44'(r_w) * 44'(r_x_c) + 44'd134217728;
    assign mag = 15'(wx[43:28]);

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_x_a    <= n_x;
            r_x2_a   <= 29'(30'(n_x) * 30'(n_x));
            r_quad_a <= i_phase[15:14];
        end
        if (i_en[1]) begin
            r_u      <= n_u;
            r_x_b    <= r_x_a;
            r_x2_b   <= r_x2_a;
            r_quad_b <= r_quad_a;
        end
        if (i_en[2]) begin
            r_w      <= n_w;
            r_x_c    <= r_x_b;
            r_quad_c <= r_quad_b;
        end
        if (i_en[3]) begin
            if (r_quad_c[1]) begin
                r_sin <= -$signed({1'b0, mag});
            end else begin
                r_sin <= $signed({1'b0, mag});
            end
        end
    end

    assign o_sin = r_sin;

endmodule

`default_nettype wire

// ===== rtl/zep_matrix.sv =====
// ----------------------------------------------------------------------------
// zep_matrix
// Three-stage product, sum and round pipeline forming the rotation matrix.
// ----------------------------------------------------------------------------
`default_nettype none

module zep_matrix
    import zep_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic [N_MAT_STAGES-1:0] i_en,
    input  wire t_q14                    i_sa,
    input  wire t_q14                    i_ca,
    input  wire t_q14                    i_sb,
    input  wire t_q14                    i_cb,
    input  wire t_q14                    i_sg,
    input  wire t_q14                    i_cg,
    output t_q14                         o_rot [N_ROT]
);

    // Stage one: pairwise Q28 products.
    logic signed [31:0] r_cbcg, r_cbsg, r_sasg, r_casg, r_sacg, r_cacg;
    logic signed [31:0] r_sbcg, r_sbsg, r_casb, r_sasb;
    t_q14               r_sa, r_ca, r_cb;

    // Stage two: Q42 terms of each entry.
    logic signed [47:0] r_ta [N_ROT];
    logic signed [47:0] r_tb [N_ROT];

    t_q14               r_rot [N_ROT];

    logic signed [47:0] n_sum [N_ROT];
    logic signed [47:0] n_rnd [N_ROT];
    logic signed [19:0] n_q14 [N_ROT];

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_cbcg <= 32'(i_cb * i_cg);
            r_cbsg <= 32'(i_cb * i_sg);
            r_sasg <= 32'(i_sa * i_sg);
            r_casg <= 32'(i_ca * i_sg);
            r_sacg <= 32'(i_sa * i_cg);
            r_cacg <= 32'(i_ca * i_cg);
            r_sbcg <= 32'(i_sb * i_cg);
            r_sbsg <= 32'(i_sb * i_sg);
            r_casb <= 32'(i_ca * i_sb);
            r_sasb <= 32'(i_sa * i_sb);
            r_sa   <= i_sa;
            r_ca   <= i_ca;
            r_cb   <= i_cb;
        end
        if (i_en[1]) begin
            r_ta[0] <= 48'(r_ca) * 48'(r_cbcg);
            r_tb[0] <= 48'(r_sasg) <<< 14;
            r_ta[1] <= 48'(r_sa) * 48'(r_cbcg);
            r_tb[1] <= 48'(r_casg) <<< 14;
            r_ta[2] <= 48'(r_sbcg) <<< 14;
            r_tb[2] <= '0;
            r_ta[3] <= 48'(r_ca) * 48'(r_cbsg);
            r_tb[3] <= 48'(r_sacg) <<< 14;
            r_ta[4] <= 48'(r_sa) * 48'(r_cbsg);
            r_tb[4] <= 48'(r_cacg) <<< 14;
            r_ta[5] <= 48'(r_sbsg) <<< 14;
            r_tb[5] <= '0;
            r_ta[6] <= 48'(r_casb) <<< 14;
            r_tb[6] <= '0;
            r_ta[7] <= 48'(r_sasb) <<< 14;
            r_tb[7] <= '0;
            r_ta[8] <= 48'(r_cb) <<< 28;
            r_tb[8] <= '0;
        end
        if (i_en[2]) begin
            for (int k = 0; k < N_ROT; k++) begin
                r_rot[k] <= 16'(n_q14[k]);
            end
        end
    end

    // Round half up to Q14 by an arithmetic shift, then clamp to plus or minus one.
    always_comb begin
        for (int k = 0; k < N_ROT; k++) begin
            n_sum[k] = (ROT_NEG_A[k] ? -r_ta[k] : r_ta[k])
                     + (ROT_NEG_B[k] ? -r_tb[k] : r_tb[k]);
            n_rnd[k] = (n_sum[k] + ROUND_HALF) >>> 28;
            if (20'(n_rnd[k]) > Q14_POS_ONE) begin
                n_q14[k] = Q14_POS_ONE;
            end else if (20'(n_rnd[k]) < Q14_NEG_ONE) begin
                n_q14[k] = Q14_NEG_ONE;
            end else begin
                n_q14[k] = 20'(n_rnd[k]);
            end
        end
    end

    assign o_rot = r_rot;

endmodule

`default_nettype wire

// ===== rtl/zyz_euler_pose_matrix_core.sv =====
// ----------------------------------------------------------------------------
// zyz_euler_pose_matrix_core
// Z-Y-Z Euler angles and position to a homogeneous pose matrix.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries three binary angles (65536 per turn) and a Q16.16 position.
//   o_out returns R = Rz(alpha) * Ry(beta) * Rz(gamma) as nine Q1.14 entries
//   saturated to plus or minus one, and the position unchanged.
//   Both channels are valid/ready; a transfer happens when both are high.
//   From input transfer to output valid an item passes four stages of
//   the sine polynomial (six sine lanes, cosine as a quarter-turn shift) and
//   three stages of products, sums and rounding.
//   Throughput is one item per cycle when not stalled; each stage has its
//   own valid bit and takes a new item when it is empty or its item moves
//   on, so bubbles close up and input keeps flowing while a finished result
//   waits. When the receiver stalls, items stack up in the stages; ready at the
//   input falls only when all seven stages are full. Nothing is dropped.
//   Reset clears all valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module zyz_euler_pose_matrix_core
    import zep_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    zep_in_if.sink    i_in,
    zep_out_if.source o_out
);

    logic [N_STAGES-1:0] r_valid;
    logic [N_STAGES-1:0] n_valid;
    logic [N_STAGES-1:0] stage_en;
    t_pipe_ctl           ctl;
    t_pos                r_pos [N_STAGES];
    t_q14                sa, ca, sb, cb, sg, cg;
    t_q14                rot [N_ROT];

    always_comb begin
        stage_en[N_STAGES-1] = !r_valid[N_STAGES-1] || o_out.ready;
        for (int k = N_STAGES - 2; k >= 0; k--) begin
            stage_en[k] = !r_valid[k] || stage_en[k+1];
        end
        n_valid[0] = stage_en[0] ? i_in.valid : r_valid[0];
        for (int k = 1; k < N_STAGES; k++) begin
            n_valid[k] = stage_en[k] ? r_valid[k-1] : r_valid[k];
        end
    end

    assign ctl.sin_en = stage_en[N_SIN_STAGES-1:0];
    assign ctl.mat_en = stage_en[N_STAGES-1:N_SIN_STAGES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_en[0]) begin
            r_pos[0] <= '{x: i_in.pos_x, y: i_in.pos_y, z: i_in.pos_z};
        end
        for (int k = 1; k < N_STAGES; k++) begin
            if (stage_en[k]) begin
                r_pos[k] <= r_pos[k-1];
            end
        end
    end

    zep_sine u_sin_a (.i_clk, .i_en(ctl.sin_en), .i_phase(i_in.angle_alpha), .o_sin(sa));
    zep_sine u_cos_a (.i_clk, .i_en(ctl.sin_en),
                      .i_phase(i_in.angle_alpha + PHASE_QUARTER), .o_sin(ca));
    zep_sine u_sin_b (.i_clk, .i_en(ctl.sin_en), .i_phase(i_in.angle_beta), .o_sin(sb));
    zep_sine u_cos_b (.i_clk, .i_en(ctl.sin_en),
                      .i_phase(i_in.angle_beta + PHASE_QUARTER), .o_sin(cb));
    zep_sine u_sin_g (.i_clk, .i_en(ctl.sin_en), .i_phase(i_in.angle_gamma), .o_sin(sg));
    zep_sine u_cos_g (.i_clk, .i_en(ctl.sin_en),
                      .i_phase(i_in.angle_gamma + PHASE_QUARTER), .o_sin(cg));

    zep_matrix u_matrix (
        .i_clk,
        .i_en  (ctl.mat_en),
        .i_sa  (sa),
        .i_ca  (ca),
        .i_sb  (sb),
        .i_cb  (cb),
        .i_sg  (sg),
        .i_cg  (cg),
        .o_rot (rot)
    );

    assign i_in.ready     = stage_en[0];
    assign o_out.valid    = r_valid[N_STAGES-1];
    assign o_out.rot_r0c0 = rot[0];
    assign o_out.rot_r1c0 = rot[1];
    assign o_out.rot_r2c0 = rot[2];
    assign o_out.rot_r0c1 = rot[3];
    assign o_out.rot_r1c1 = rot[4];
    assign o_out.rot_r2c1 = rot[5];
    assign o_out.rot_r0c2 = rot[6];
    assign o_out.rot_r1c2 = rot[7];
    assign o_out.rot_r2c2 = rot[8];
    assign o_out.trans_x  = r_pos[N_STAGES-1].x;
    assign o_out.trans_y  = r_pos[N_STAGES-1].y;
    assign o_out.trans_z  = r_pos[N_STAGES-1].z;

endmodule

`default_nettype wire

// ===== rtl/zep_checker.sv =====
// ----------------------------------------------------------------------------
// zep_checker
// Port-level assertions for the pose matrix core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module zep_checker
    import zep_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        i_in_ready,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [15:0] i_r2c2
);

    logic [3:0] r_count;

    // Items inside the block: input transfers minus output transfers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= r_count + 4'(i_in_valid && i_in_ready)
                               - 4'(i_out_valid && i_out_ready);
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output valid dropped during stall");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_count != 4'd0)
        else $error("output valid with no item inside");

    a_capacity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 4'(N_STAGES))
        else $error("more items inside than stages");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == 4'(N_STAGES) && !i_out_ready |-> !i_in_ready)
        else $error("input taken while every stage is full");

    a_r2c2_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ($signed(i_r2c2) <= 16'sd16384 && $signed(i_r2c2) >= -16'sd16384))
        else $error("rotation entry out of range");

endmodule

bind zyz_euler_pose_matrix_core zep_checker u_zep_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_r2c2      (o_out.rot_r2c2)
);

`default_nettype wire

// ===== bench/tb_pose_checker.sv =====
// ----------------------------------------------------------------------------
// tb_pose_checker
// Watches both channels of the pose matrix core, computes the expected
// rotation entries and translation for each input transfer, and compares
// every output transfer with the oldest pending pose.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_pose_checker (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    zep_in_if.sink    i_mon_in,
    zep_out_if.sink   i_mon_out,
    output int        o_fail_count,
    output int        o_pending
);

    typedef struct {
        logic signed [15:0] rot [9];
        logic signed [31:0] pos [3];
    } t_pose;

    t_pose pending_poses [$];
    int    fail_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_poses.size();

    function automatic longint poly_sin(logic [15:0] phase);
        logic [1:0]   quad;
        longint unsigned x, x2, u, w, s;
        begin
            quad = phase[15:14];
            x = {50'd0, phase[13:0]};
            if (quad[0]) begin
                x = 64'd16384 - x;
            end
            x2 = x * x;
            u = 64'd172226216 - ((64'd19004244 * x2) >> 28);
            w = 64'd421657428 - ((u * x2) >> 28);
            s = (w * x + (64'd1 << 27)) >> 28;
            return quad[1] ? -longint'(s) : longint'(s);
        end
    endfunction

    function automatic logic signed [15:0] round_q42(longint v);
        longint r;
        begin
            // Arithmetic shift gives the floor of the division.
            r = (v + (64'sd1 <<< 27)) >>> 28;
            if (r > 16384) begin
                r = 16384;
            end
            if (r < -16384) begin
                r = -16384;
            end
            return r[15:0];
        end
    endfunction

    function automatic t_pose compute_pose(logic [15:0] a, logic [15:0] b, logic [15:0] g,
                                           logic [31:0] px, logic [31:0] py,
                                           logic [31:0] pz);
        t_pose  p;
        longint sa, ca, sb, cb, sg, cg;
        begin
            sa = poly_sin(a); ca = poly_sin(a + 16'd16384);
            sb = poly_sin(b); cb = poly_sin(b + 16'd16384);
            sg = poly_sin(g); cg = poly_sin(g + 16'd16384);
            p.rot[0] = round_q42(ca * cb * cg - sa * sg * 16384);
            p.rot[1] = round_q42(sa * cb * cg + ca * sg * 16384);
            p.rot[2] = round_q42(-(sb * cg) * 16384);
            p.rot[3] = round_q42(-(ca * cb * sg) - sa * cg * 16384);
            p.rot[4] = round_q42(-(sa * cb * sg) + ca * cg * 16384);
            p.rot[5] = round_q42(sb * sg * 16384);
            p.rot[6] = round_q42(ca * sb * 16384);
            p.rot[7] = round_q42(sa * sb * 16384);
            p.rot[8] = round_q42(cb * (64'sd1 <<< 28));
            p.pos[0] = px; p.pos[1] = py; p.pos[2] = pz;
            return p;
        end
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_pose want;
        logic signed [15:0] got_rot [9];
        logic signed [31:0] got_pos [3];
        if (i_rst_n) begin
            if (i_mon_in.valid && i_mon_in.ready) begin
                pending_poses.push_back(compute_pose(i_mon_in.angle_alpha,
                    i_mon_in.angle_beta, i_mon_in.angle_gamma,
                    i_mon_in.pos_x, i_mon_in.pos_y, i_mon_in.pos_z));
            end
            if (i_mon_out.valid && i_mon_out.ready) begin
                got_rot = '{i_mon_out.rot_r0c0, i_mon_out.rot_r1c0, i_mon_out.rot_r2c0,
                            i_mon_out.rot_r0c1, i_mon_out.rot_r1c1, i_mon_out.rot_r2c1,
                            i_mon_out.rot_r0c2, i_mon_out.rot_r1c2, i_mon_out.rot_r2c2};
                got_pos = '{i_mon_out.trans_x, i_mon_out.trans_y, i_mon_out.trans_z};
                if (pending_poses.size() == 0) begin
                    report_mismatch("unexpected transfer", 0, 0);
                end else begin
                    want = pending_poses.pop_front();
                    for (int k = 0; k < 9; k++) begin
                        if (got_rot[k] !== want.rot[k]) begin
                            report_mismatch($sformatf("rot[%0d]", k), got_rot[k],
                                            want.rot[k]);
                        end
                    end
                    for (int k = 0; k < 3; k++) begin
                        if (got_pos[k] !== want.pos[k]) begin
                            report_mismatch($sformatf("trans[%0d]", k), got_pos[k],
                                            want.pos[k]);
                        end
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== bench/tb_zyz_euler_pose_matrix_core.sv =====
// ----------------------------------------------------------------------------
// tb_zyz_euler_pose_matrix_core
// Drives angle and position items into the pose matrix core with random
// gaps and output stalls; the checker beside the block scores the results.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_zyz_euler_pose_matrix_core;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   fail_count;
    int   pending;
    logic quiet = 1'b0;

    zep_in_if  pose_in ();
    zep_out_if pose_out ();

    zyz_euler_pose_matrix_core DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (pose_in.sink),
        .o_out  (pose_out.source)
    );

    tb_pose_checker checker_inst (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mon_in    (pose_in.sink),
        .i_mon_out   (pose_out.sink),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

    // Receiver stalls in bursts until the final stretch.
    initial begin
        int burst;
        pose_out.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (!quiet && $urandom_range(0, 3) == 0) begin
                burst = $urandom_range(1, 17);
                pose_out.ready <= 1'b0;
                repeat (burst) @(posedge i_clk);
            end else begin
                pose_out.ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end
        end
    end

    function automatic logic [15:0] pick_angle();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return {2'($urandom_range(0, 3)), 14'd0};
            3: return {2'($urandom_range(0, 3)), 14'd0}
                      + 16'($urandom_range(0, 2)) - 16'd1;
            default: return 16'($urandom());
        endcase
    endfunction

    task automatic send_pose(logic [15:0] a, logic [15:0] b, logic [15:0] g,
                             logic [31:0] px, logic [31:0] py, logic [31:0] pz);
        pose_in.valid       <= 1'b1;
        pose_in.angle_alpha <= a;
        pose_in.angle_beta  <= b;
        pose_in.angle_gamma <= g;
        pose_in.pos_x       <= px;
        pose_in.pos_y       <= py;
        pose_in.pos_z       <= pz;
        @(posedge i_clk);
        while (!pose_in.ready) @(posedge i_clk);
    endtask

    task automatic sender_gap();
        if (!quiet && $urandom_range(0, 4) == 0) begin
            pose_in.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
    endtask

    initial begin
        logic [15:0] edge_angles [8];
        int wait_cycles;
        edge_angles = '{16'h0000, 16'h4000, 16'h8000, 16'hC000,
                        16'h7FFF, 16'h0001, 16'hFFFF, 16'h3FFF};
        pose_in.valid <= 1'b0;
        pose_in.angle_alpha <= '0;
        pose_in.angle_beta  <= '0;
        pose_in.angle_gamma <= '0;
        pose_in.pos_x <= '0;
        pose_in.pos_y <= '0;
        pose_in.pos_z <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Quarter and half turns and angles one step off them, including the half
        // turn at the most negative angle, with extreme positions.
        for (int k = 0; k < 8; k++) begin
            send_pose(edge_angles[k], edge_angles[(k + 3) % 8], edge_angles[(k + 5) % 8],
                      32'h8000_0000, 32'h7FFF_FFFF, k[0] ? 32'hFFFF_FFFF : 32'h0);
            sender_gap();
        end
        for (int k = 0; k < 8; k++) begin
            send_pose(edge_angles[k], edge_angles[k], edge_angles[k],
                      32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000);
        end
        send_pose(16'h8000, 16'h8000, 16'h8000, 32'hFFFF_FFFF, 32'h0, 32'h8000_0000);

        // Hold off until the pipeline has drained completely or the wait limit runs out.
        pose_in.valid <= 1'b0;
        wait_cycles = 0;
        while (pending != 0 && wait_cycles < 10000) begin
            @(posedge i_clk);
            wait_cycles++;
        end

        for (int n = 0; n < 400; n++) begin
            if (n == 340) begin
                quiet <= 1'b1;
            end
            send_pose(pick_angle(), pick_angle(), pick_angle(),
                      $urandom(), $urandom(), $urandom());
            sender_gap();
        end
        pose_in.valid <= 1'b0;

        wait_cycles = 0;
        while (pending != 0 && wait_cycles < 20000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

`default_nettype wire
